>>> rtl/core/fcba_pkg.sv
package fcba_pkg;

  localparam int unsigned NUM_BLOCKS  = 256;
  localparam int unsigned ENTRY_WIDTH = 16;
  localparam int unsigned ADDR_W      = $clog2(NUM_BLOCKS);
  localparam int unsigned SPAN_W      = ADDR_W + 1;

  localparam logic [ENTRY_WIDTH-1:0] MARK_FREE = 16'hFFFC;
  localparam logic [ENTRY_WIDTH-1:0] MARK_END  = 16'hFFFA;

  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_ALLOC  = 3'd2;
  localparam logic [2:0] OP_FREE   = 3'd3;
  localparam logic [2:0] OP_COUNT  = 3'd4;
  localparam logic [2:0] OP_VERIFY = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_BADTYPE = 3'd2;
  localparam logic [2:0] ST_SHORT   = 3'd3;
  localparam logic [2:0] ST_CORRUPT = 3'd4;
  localparam logic [2:0] ST_EARLY   = 3'd5;
  localparam logic [2:0] ST_LONG    = 3'd6;

  localparam logic [2:0] CFG_BLOCK_COUNT   = 3'd0;
  localparam logic [2:0] CFG_HIDDEN_START  = 3'd1;
  localparam logic [2:0] CFG_HIDDEN_BLOCKS = 3'd2;
  localparam logic [2:0] CFG_DIR_START     = 3'd3;
  localparam logic [2:0] CFG_DIR_BLOCKS    = 3'd4;

  typedef enum logic [1:0] {RA_IDX, RA_CAND, RA_BLK, RA_PTR} rd_sel_t;
  typedef enum logic [1:0] {WA_IDX, WA_CUR, WA_BLK} wa_sel_t;
  typedef enum logic [1:0] {WD_EV, WD_END, WD_FREE, WD_CAND} wd_sel_t;
  typedef enum logic [1:0] {VS_ZERO, VS_RDATA, VS_CNT, VS_FIRST} val_sel_t;

  typedef struct packed {
    logic       ld_item;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       wr_en;
    wa_sel_t    wa_sel;
    wd_sel_t    wd_sel;
    logic       ptr_inc;
    logic       ptr_start;
    logic       ptr_step;
    logic       cnt_inc;
    logic       take_first;
    logic       take_cur;
    logic       left_dec;
    logic       blk_load;
    logic       finish;
    logic [2:0] fin_status;
    val_sel_t   val_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       len_zero;
    logic       cnt_short;
    logic       type_bad;
    logic       left_gt1;
    logic       left_zero;
    logic       blk_end;
    logic       blk_free;
    logic       blk_ge_lim;
    logic       scan_done;
    logic       search_done;
    logic       rd_free;
    logic       have_first;
  } dp_sts_t;

endpackage

>>> rtl/core/fat_chain_block_allocator_core.sv
// Channel   Handshake                  Beat
// command   start & !busy              opcode, block_index, entry_value, file_type, length
// result    done (one cycle strobe)    status, value
// config    cfg_valid & cfg_ready      cfg_index, cfg_data
//
// Load writes its entry in the dispatch state; read adds a wait state for the table
// read data. Count walks min(block_count, NUM_BLOCKS) table entries, one entry per read/compare
// pair on the single read port. Allocate adds a count pass and a fresh search per
// chain block; free and verify walk each link through a read state and a check state.
// Reset (rst, synchronous) restores the config registers; the table is
// undefined until loaded. cfg_ready is always high. The receiver cannot
// stall: done is high for exactly one cycle per command.
module fat_chain_block_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [7:0]  block_index,
  input  logic [15:0] entry_value,
  input  logic [1:0]  file_type,
  input  logic [7:0]  length,
  output logic        done,
  output logic [2:0]  status,
  output logic [15:0] value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import fcba_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    start_gated;

  // config writes must land only while idle (the user's duty, not enforced here); always accept them
  assign cfg_ready   = 1'b1;
  assign start_gated = start && !busy;

  fcba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start_gated),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  fcba_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .opcode      (opcode),
    .block_index (block_index),
    .entry_value (entry_value),
    .file_type   (file_type),
    .length      (length),
    .cmd         (cmd),
    .sts         (sts),
    .done        (done),
    .status      (status),
    .value       (value)
  );

endmodule

>>> rtl/core/fcba_dp.sv
module fcba_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [8:0]           cfg_data,
  input  logic [2:0]           opcode,
  input  logic [7:0]           block_index,
  input  logic [15:0]          entry_value,
  input  logic [1:0]           file_type,
  input  logic [7:0]           length,
  input  fcba_pkg::dp_cmd_t    cmd,
  output fcba_pkg::dp_sts_t    sts,
  output logic                 done,
  output logic [2:0]           status,
  output logic [15:0]          value
);
  import fcba_pkg::*;

  logic [15:0]       fat_mem [NUM_BLOCKS];
  logic [15:0]       rdata;
  logic [8:0]        block_count;
  logic [7:0]        hidden_start, hidden_blocks, dir_start, dir_blocks;
  logic [2:0]        op;
  logic [7:0]        idx, len, left, cur, first;
  logic [15:0]       ev, blk;
  logic [1:0]        ftype;
  logic              have_first;
  logic [SPAN_W-1:0] ptr, ptr_m1, cnt, lim, utop;
  logic [7:0]        diff_a, diff_b;
  logic [ADDR_W-1:0] cand, raddr, waddr;
  logic [15:0]       wdata;
  logic              down;

  // derive the user-area top and the link bound
  always_comb begin
    if (hidden_blocks != 8'd0) begin
      diff_a = hidden_start;
      diff_b = hidden_blocks;
    end else begin
      diff_a = dir_start;
      diff_b = dir_blocks;
    end
    utop = (diff_a < diff_b) ? '0 : {1'b0, diff_a - diff_b};
    lim  = (block_count > SPAN_W'(NUM_BLOCKS)) ? SPAN_W'(NUM_BLOCKS) : block_count;
  end

  assign down   = (ftype == 2'd0);
  assign ptr_m1 = ptr - SPAN_W'(1);
  assign cand   = down ? ptr_m1[ADDR_W-1:0] : ptr[ADDR_W-1:0];

  always_comb begin
    case (cmd.rd_sel)
      RA_IDX:  raddr = idx;
      RA_CAND: raddr = cand;
      RA_PTR:  raddr = ptr[ADDR_W-1:0];
      default: raddr = blk[ADDR_W-1:0];
    endcase
    case (cmd.wa_sel)
      WA_IDX:  waddr = idx;
      WA_CUR:  waddr = cur;
      default: waddr = blk[ADDR_W-1:0];
    endcase
    case (cmd.wd_sel)
      WD_EV:   wdata = ev;
      WD_END:  wdata = MARK_END;
      WD_FREE: wdata = MARK_FREE;
      default: wdata = {8'd0, cand};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      fat_mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= fat_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count   <= 9'd256;
      hidden_start  <= 8'd0;
      hidden_blocks <= 8'd0;
      dir_start     <= 8'd253;
      dir_blocks    <= 8'd13;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_COUNT:   block_count   <= cfg_data;
        CFG_HIDDEN_START:  hidden_start  <= cfg_data[7:0];
        CFG_HIDDEN_BLOCKS: hidden_blocks <= cfg_data[7:0];
        CFG_DIR_START:     dir_start     <= cfg_data[7:0];
        CFG_DIR_BLOCKS:    dir_blocks    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      op         <= opcode;
      idx        <= block_index;
      ev         <= entry_value;
      ftype      <= file_type;
      len        <= length;
      left       <= length;
      blk        <= {8'd0, block_index};
      ptr        <= '0;
      cnt        <= '0;
      first      <= '0;
      have_first <= 1'b0;
    end else begin
      if (cmd.ptr_inc) ptr <= ptr + SPAN_W'(1);
      if (cmd.ptr_start) ptr <= down ? utop : '0;
      if (cmd.ptr_step) ptr <= down ? ptr_m1 : ptr + SPAN_W'(1);
      if (cmd.cnt_inc) cnt <= cnt + SPAN_W'(1);
      if (cmd.take_first) begin
        first      <= cand;
        have_first <= 1'b1;
      end
      if (cmd.take_cur) cur <= cand;
      if (cmd.left_dec) left <= left - 8'd1;
      if (cmd.blk_load) blk <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      status <= cmd.fin_status;
      case (cmd.val_sel)
        VS_RDATA: value <= rdata;
        VS_CNT:   value <= 16'(cnt);
        VS_FIRST: value <= {8'd0, first};
        default:  value <= 16'd0;
      endcase
    end
  end

  always_comb begin
    sts.op          = op;
    sts.len_zero    = (len == 8'd0);
    sts.cnt_short   = (cnt < {1'b0, len});
    sts.type_bad    = (ftype > 2'd1);
    sts.left_gt1    = (left > 8'd1);
    sts.left_zero   = (left == 8'd0);
    sts.blk_end     = (blk == MARK_END);
    sts.blk_free    = (blk == MARK_FREE);
    sts.blk_ge_lim  = (blk >= 16'(lim));
    sts.scan_done   = (ptr >= lim);
    sts.search_done = down ? (ptr == '0) : (ptr >= utop);
    sts.rd_free     = (rdata == MARK_FREE);
    sts.have_first  = have_first;
  end

endmodule

>>> rtl/core/fcba_ctrl.sv
module fcba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  fcba_pkg::dp_sts_t sts,
  output fcba_pkg::dp_cmd_t cmd
);
  import fcba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_READ_WAIT, S_CNT_RD, S_CNT_CHK, S_SRCH_RD, S_SRCH_CHK,
    S_LINK, S_FREE_CHK, S_FREE_WR, S_VER_CHK, S_VER_WAIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.ld_item = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_LOAD: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_IDX;
            cmd.wd_sel = WD_EV;
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
          OP_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_IDX;
            state_next = S_READ_WAIT;
          end
          OP_ALLOC: begin
            if (sts.len_zero) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_SHORT;
              state_next     = S_IDLE;
            end else begin
              state_next = S_CNT_RD;
            end
          end
          OP_COUNT:  state_next = S_CNT_RD;
          OP_FREE:   state_next = S_FREE_CHK;
          OP_VERIFY: state_next = S_VER_CHK;
          default: begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_READ_WAIT: begin
        cmd.finish  = 1'b1;
        cmd.val_sel = VS_RDATA;
        state_next  = S_IDLE;
      end
      S_CNT_RD: begin
        if (sts.scan_done) begin
          if (sts.op == OP_COUNT) begin
            cmd.finish  = 1'b1;
            cmd.val_sel = VS_CNT;
            state_next  = S_IDLE;
          end else if (sts.cnt_short) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_NOSPACE;
            state_next     = S_IDLE;
          end else if (sts.type_bad) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_BADTYPE;
            state_next     = S_IDLE;
          end else begin
            cmd.ptr_start = 1'b1;
            state_next    = S_SRCH_RD;
          end
        end else begin
          // count pass walks upward from entry 0 whatever the file type
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_PTR;
          state_next = S_CNT_CHK;
        end
      end
      S_CNT_CHK: begin
        cmd.cnt_inc = sts.rd_free;
        cmd.ptr_inc = 1'b1;
        state_next  = S_CNT_RD;
      end
      S_SRCH_RD: begin
        if (sts.search_done) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_NOSPACE;
          cmd.val_sel    = VS_FIRST;
          state_next     = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_CAND;
          state_next = S_SRCH_CHK;
        end
      end
      S_SRCH_CHK: begin
        if (sts.rd_free) begin
          cmd.take_cur = 1'b1;
          if (!sts.have_first) begin
            cmd.take_first = 1'b1;
          end else begin
            // link the previous block to the one just found
            cmd.wr_en    = 1'b1;
            cmd.wa_sel   = WA_CUR;
            cmd.wd_sel   = WD_CAND;
            cmd.left_dec = 1'b1;
          end
          state_next = S_LINK;
        end else begin
          cmd.ptr_step = 1'b1;
          state_next   = S_SRCH_RD;
        end
      end
      S_LINK: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_CUR;
        cmd.wd_sel = WD_END;
        if (sts.left_gt1) begin
          cmd.ptr_start = 1'b1;
          state_next    = S_SRCH_RD;
        end else begin
          cmd.finish  = 1'b1;
          cmd.val_sel = VS_FIRST;
          state_next  = S_IDLE;
        end
      end
      S_FREE_CHK: begin
        if (sts.blk_end) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else if (sts.blk_free || sts.blk_ge_lim) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_CORRUPT;
          state_next     = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_BLK;
          state_next = S_FREE_WR;
        end
      end
      S_FREE_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wa_sel   = WA_BLK;
        cmd.wd_sel   = WD_FREE;
        cmd.blk_load = 1'b1;
        state_next   = S_FREE_CHK;
      end
      S_VER_CHK: begin
        if (sts.left_zero) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = sts.blk_end ? ST_OK : ST_LONG;
          state_next     = S_IDLE;
        end else if (sts.blk_end || sts.blk_free) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_EARLY;
          state_next     = S_IDLE;
        end else if (sts.blk_ge_lim) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_CORRUPT;
          state_next     = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_BLK;
          state_next = S_VER_WAIT;
        end
      end
      S_VER_WAIT: begin
        cmd.blk_load = 1'b1;
        cmd.left_dec = 1'b1;
        state_next   = S_VER_CHK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

>>> bench/fat_chain_block_allocator_core_test.sv
module fat_chain_block_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fcba_pkg::*;

  // Block ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  opcode = OP_LOAD;
  logic [7:0]  block_index = '0;
  logic [15:0] entry_value = '0;
  logic [1:0]  file_type = '0;
  logic [7:0]  length = '0;
  logic        done;
  logic [2:0]  status;
  logic [15:0] value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_BLOCK_COUNT;
  logic [8:0]  cfg_data = '0;

  // Opcodes 6 and 7 are unused by the block; name them for the stimulus.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]  st;
    logic [15:0] val;
  } outcome_t;

  // Shadow copy of the allocation table and the config registers
  logic [15:0] shadow_fat [NUM_BLOCKS];
  logic [8:0]  sh_block_count;
  logic [7:0]  sh_hidden_start, sh_hidden_blocks, sh_dir_start, sh_dir_blocks;

  outcome_t    pending_outcomes[$];
  int          chain_heads[$];
  int          chain_lens[$];
  int          fail_count = 0;

  fat_chain_block_allocator_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .block_index(block_index), .entry_value(entry_value),
    .file_type(file_type), .length(length),
    .done(done), .status(status), .value(value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor: table helpers
  // ---------------------------------------------------------------------
  function automatic int span_limit();
    return (sh_block_count < NUM_BLOCKS) ? int'(sh_block_count) : NUM_BLOCKS;
  endfunction

  function automatic int area_top();
    int t;
    if (sh_hidden_blocks != 0) t = int'(sh_hidden_start) - int'(sh_hidden_blocks);
    else t = int'(sh_dir_start) - int'(sh_dir_blocks);
    if (t < 0) t = 0;
    if (t > NUM_BLOCKS) t = NUM_BLOCKS;
    return t;
  endfunction

  function automatic int free_total();
    int n;
    n = 0;
    for (int i = 0; i < span_limit(); i++)
      if (shadow_fat[i] == MARK_FREE) n++;
    return n;
  endfunction

  // Find a free block in the user area; -1 when none.
  function automatic int find_free(logic [1:0] ft);
    int top;
    top = area_top();
    if (ft == 2'd0) begin
      for (int i = top - 1; i >= 0; i--)
        if (shadow_fat[i] == MARK_FREE) return i;
    end else begin
      for (int i = 0; i < top; i++)
        if (shadow_fat[i] == MARK_FREE) return i;
    end
    return -1;
  endfunction

  function automatic outcome_t alloc_chain(logic [1:0] ft, logic [7:0] len);
    outcome_t o;
    int cur, nxt;
    o.st = ST_OK;
    o.val = '0;
    if (len == 0) begin
      o.st = ST_SHORT;
      return o;
    end
    if (free_total() < len) begin
      o.st = ST_NOSPACE;
      return o;
    end
    if (ft > 2'd1) begin
      o.st = ST_BADTYPE;
      return o;
    end
    cur = find_free(ft);
    if (cur < 0) begin
      o.st = ST_NOSPACE;
      return o;
    end
    o.val = 16'(cur);
    // Terminate each block before searching for the next one.
    for (int left = len; left > 1; left--) begin
      shadow_fat[cur] = MARK_END;
      nxt = find_free(ft);
      if (nxt < 0) begin
        o.st = ST_NOSPACE;
        return o;
      end
      shadow_fat[cur] = 16'(nxt);
      cur = nxt;
    end
    shadow_fat[cur] = MARK_END;
    return o;
  endfunction

  function automatic logic [2:0] free_walk(logic [15:0] blk);
    logic [15:0] nxt;
    while (blk != MARK_END) begin
      if (blk == MARK_FREE || blk >= span_limit()) return ST_CORRUPT;
      nxt = shadow_fat[blk[7:0]];
      shadow_fat[blk[7:0]] = MARK_FREE;
      blk = nxt;
    end
    return ST_OK;
  endfunction

  function automatic logic [2:0] verify_walk(logic [15:0] blk, logic [7:0] len);
    for (int n = len; n > 0; n--) begin
      if (blk == MARK_FREE || blk == MARK_END) return ST_EARLY;
      if (blk >= span_limit()) return ST_CORRUPT;
      blk = shadow_fat[blk[7:0]];
    end
    return (blk == MARK_END) ? ST_OK : ST_LONG;
  endfunction

  function automatic outcome_t predict_command(logic [2:0] op, logic [7:0] idx,
                                               logic [15:0] ev, logic [1:0] ft,
                                               logic [7:0] len);
    outcome_t o;
    o.st = ST_OK;
    o.val = '0;
    case (op)
      OP_LOAD:   shadow_fat[idx] = ev;
      OP_READ:   o.val = shadow_fat[idx];
      OP_ALLOC:  o = alloc_chain(ft, len);
      OP_FREE:   o.st = free_walk({8'd0, idx});
      OP_COUNT:  o.val = 16'(free_total());
      OP_VERIFY: o.st = verify_walk({8'd0, idx}, len);
      default: ;
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: every done beat is compared with the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%0h", $time, status, value);
        fail_count++;
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (status !== exp_o.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_o.st, status);
          fail_count++;
        end
        if (value !== exp_o.val) begin
          $display("%0t: value expected %0h actual %0h", $time, exp_o.val, value);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driving tasks (inputs change at the falling edge)
  // ---------------------------------------------------------------------
  task automatic send_command(logic [2:0] op, logic [7:0] idx, logic [15:0] ev,
                              logic [1:0] ft, logic [7:0] len);
    int gap;
    outcome_t o;
    gap = $urandom_range(0, 12);
    // Leave long runs back to back now and then.
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    opcode <= op;
    block_index <= idx;
    entry_value <= ev;
    file_type <= ft;
    length <= len;
    // Hold the beat until the block takes it.
    do @(posedge clk); while (busy);
    o = predict_command(op, idx, ev, ft, len);
    pending_outcomes.push_back(o);
    if (op == OP_ALLOC && o.st == ST_OK) begin
      chain_heads.push_back(o.val);
      chain_lens.push_back(len);
      if (chain_heads.size() > 64) begin
        void'(chain_heads.pop_front());
        void'(chain_lens.pop_front());
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Config beats go only to an idle block.
  task automatic write_register(logic [2:0] ridx, logic [8:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= ridx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (ridx)
      CFG_BLOCK_COUNT:   sh_block_count = data;
      CFG_HIDDEN_START:  sh_hidden_start = data[7:0];
      CFG_HIDDEN_BLOCKS: sh_hidden_blocks = data[7:0];
      CFG_DIR_START:     sh_dir_start = data[7:0];
      CFG_DIR_BLOCKS:    sh_dir_blocks = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_layout(logic [8:0] bc, logic [7:0] hs, logic [7:0] hb,
                            logic [7:0] ds, logic [7:0] db);
    write_register(CFG_BLOCK_COUNT, bc);
    write_register(CFG_HIDDEN_START, {1'b0, hs});
    write_register(CFG_HIDDEN_BLOCKS, {1'b0, hb});
    write_register(CFG_DIR_START, {1'b0, ds});
    write_register(CFG_DIR_BLOCKS, {1'b0, db});
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Write every entry so no later scan touches an undefined word.
  task automatic test_table_init();
    for (int i = 0; i < NUM_BLOCKS; i++)
      send_command(OP_LOAD, 8'(i), MARK_FREE, 2'd0, 8'd0);
  endtask

  task automatic test_directed();
    // Extremes of load/read
    send_command(OP_LOAD, 8'd255, 16'hFFFF, 2'd3, 8'd255);
    send_command(OP_READ, 8'd255, 16'h0000, 2'd0, 8'd0);
    send_command(OP_LOAD, 8'd255, MARK_FREE, 2'd0, 8'd0);
    send_command(OP_LOAD, 8'd0, 16'h0000, 2'd0, 8'd0);
    send_command(OP_READ, 8'd0, 16'hFFFF, 2'd0, 8'd0);
    send_command(OP_LOAD, 8'd0, MARK_FREE, 2'd0, 8'd0);
    send_command(OP_COUNT, 8'd0, 16'd0, 2'd0, 8'd0);
    // Allocate checks: zero length, not enough space, unknown types
    send_command(OP_ALLOC, 8'd0, 16'd0, 2'd0, 8'd0);
    send_command(OP_ALLOC, 8'd0, 16'd0, 2'd2, 8'd3);
    send_command(OP_ALLOC, 8'd0, 16'd0, 2'd3, 8'd1);
    send_command(OP_ALLOC, 8'd0, 16'd0, 2'd1, 8'd255);
    // Data chain from the top, game chain from the bottom
    send_command(OP_ALLOC, 8'd0, 16'd0, 2'd0, 8'd3);
    send_command(OP_ALLOC, 8'd0, 16'd0, 2'd1, 8'd4);
    send_command(OP_VERIFY, 8'd0, 16'd0, 2'd0, 8'd4);
    send_command(OP_VERIFY, 8'd0, 16'd0, 2'd0, 8'd3);
    send_command(OP_VERIFY, 8'd0, 16'd0, 2'd0, 8'd5);
    send_command(OP_VERIFY, 8'd0, 16'd0, 2'd0, 8'd0);
    send_command(OP_VERIFY, 8'd100, 16'd0, 2'd0, 8'd1);
    send_command(OP_FREE, 8'd0, 16'd0, 2'd0, 8'd0);
    send_command(OP_FREE, 8'd0, 16'd0, 2'd0, 8'd0);
    send_command(OP_SPARE6, 8'd7, 16'h1234, 2'd1, 8'd9);
    send_command(OP_SPARE7, 8'd255, 16'hFFFF, 2'd3, 8'd255);
    // Chain link beyond the used block count gives corrupt
    send_command(OP_LOAD, 8'd10, 16'd200, 2'd0, 8'd0);
    set_layout(9'd100, 8'd0, 8'd0, 8'd253, 8'd13);
    send_command(OP_FREE, 8'd10, 16'd0, 2'd0, 8'd0);
    send_command(OP_VERIFY, 8'd11, 16'd0, 2'd0, 8'd2);
    send_command(OP_FREE, 8'd150, 16'd0, 2'd0, 8'd0);
    // Failure partway: plenty free overall, little inside the user area
    set_layout(9'd256, 8'd6, 8'd2, 8'd253, 8'd13);
    send_command(OP_ALLOC, 8'd0, 16'd0, 2'd0, 8'd8);
    send_command(OP_ALLOC, 8'd0, 16'd0, 2'd1, 8'd2);
    // Empty user area and an empty used span
    set_layout(9'd256, 8'd0, 8'd0, 8'd5, 8'd200);
    send_command(OP_ALLOC, 8'd0, 16'd0, 2'd1, 8'd1);
    set_layout(9'd0, 8'd255, 8'd255, 8'd0, 8'd0);
    send_command(OP_COUNT, 8'd0, 16'd0, 2'd0, 8'd0);
    send_command(OP_ALLOC, 8'd0, 16'd0, 2'd0, 8'd1);
    send_command(OP_FREE, 8'd3, 16'd0, 2'd0, 8'd0);
  endtask

  // Random item: mostly well-formed allocate/verify/free traffic on live chains.
  task automatic random_item();
    int pick, k;
    logic [15:0] ev;
    logic [7:0]  len;
    pick = $urandom_range(0, 99);
    k = (chain_heads.size() > 0) ? $urandom_range(0, chain_heads.size() - 1) : -1;
    if (pick < 12) begin
      case ($urandom_range(0, 3))
        0: ev = MARK_FREE;
        1: ev = MARK_END;
        2: ev = 16'($urandom_range(0, 255));
        default: ev = 16'($urandom);
      endcase
      send_command(OP_LOAD, 8'($urandom), ev, 2'($urandom), 8'($urandom));
    end else if (pick < 20) begin
      send_command(OP_READ, 8'($urandom), 16'($urandom), 2'($urandom), 8'($urandom));
    end else if (pick < 45) begin
      len = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 40))
                                         : 8'($urandom_range(1, 5));
      send_command(OP_ALLOC, 8'($urandom), 16'($urandom),
                   ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'($urandom_range(0, 1)),
                   len);
    end else if (pick < 68) begin
      if (k >= 0 && $urandom_range(0, 4) != 0) begin
        send_command(OP_FREE, 8'(chain_heads[k]), 16'($urandom), 2'($urandom), 8'($urandom));
        chain_heads.delete(k);
        chain_lens.delete(k);
      end else begin
        send_command(OP_FREE, 8'($urandom), 16'($urandom), 2'($urandom), 8'($urandom));
      end
    end else if (pick < 90) begin
      if (k >= 0 && $urandom_range(0, 4) != 0)
        send_command(OP_VERIFY, 8'(chain_heads[k]), 16'($urandom), 2'($urandom),
                     8'(chain_lens[k] + $urandom_range(0, 2) - 1));
      else
        send_command(OP_VERIFY, 8'($urandom), 16'($urandom), 2'($urandom),
                     8'($urandom_range(0, 255)));
    end else if (pick < 97) begin
      send_command(OP_COUNT, 8'($urandom), 16'($urandom), 2'($urandom), 8'($urandom));
    end else begin
      send_command(($urandom_range(0, 1) != 0) ? OP_SPARE6 : OP_SPARE7, 8'($urandom),
                   16'($urandom), 2'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random_layouts();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_layout(9'd256, 8'd0, 8'd0, 8'd253, 8'd13);
        1: set_layout(9'd511, 8'd255, 8'd1, 8'd0, 8'd0);
        2: set_layout(9'($urandom_range(16, 256)), 8'($urandom), 8'd0,
                      8'($urandom), 8'($urandom_range(0, 40)));
        3: set_layout(9'd200, 8'd128, 8'd255, 8'd255, 8'd255);
        4: set_layout(9'd257, 8'd250, 8'd30, 8'd7, 8'd1);
        default: set_layout(9'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom));
      endcase
      for (int n = 0; n < 230; n++) random_item();
    end
  endtask

  // Hold the sender until the block has answered everything, then resume.
  task automatic test_sender_pause();
    for (int n = 0; n < 30; n++) begin
      random_item();
      if (n % 10 == 9) drain();
    end
  endtask

  initial begin
    sh_block_count = 9'd256;
    sh_hidden_start = 8'd0;
    sh_hidden_blocks = 8'd0;
    sh_dir_start = 8'd253;
    sh_dir_blocks = 8'd13;
    for (int i = 0; i < NUM_BLOCKS; i++) shadow_fat[i] = MARK_FREE;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_table_init();
    test_directed();
    test_random_layouts();
    test_sender_pause();
    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("fat_chain_block_allocator_core_test passed");
    else
      $display("fat_chain_block_allocator_core_test failed");
    $finish;
  end

  initial begin
    #400ms;
    $display("fat_chain_block_allocator_core_test failed");
    $finish;
  end

endmodule

>>> fat_chain_block_allocator_core.f
rtl/core/fcba_pkg.sv
rtl/core/fcba_dp.sv
rtl/core/fcba_ctrl.sv
rtl/core/fat_chain_block_allocator_core.sv
bench/fat_chain_block_allocator_core_test.sv
